FILE: rtl/lfuct_pkg.sv
package lfuct_pkg;

  localparam int KEY_BITS       = 32;
  localparam int VALUE_BITS     = 32;
  localparam int CAP_BITS       = 5;
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } rsp_t;

  typedef struct packed {
    logic req_load;
    logic match_load;
    logic free_load;
    logic scan_start;
    logic scan_step;
    logic pick_load;
    logic promote;
    logic bump_count;
    logic fill_slot;
    logic insert;
    logic val_write;
    logic res_load;
    logic res_hit;
    logic res_read;
    logic res_evict;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic is_put;
    logic cap_zero;
    logic full;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/lfu_cache_table.sv
// Key-value cache with least-frequently-used replacement; among entries with
// equal use counts the least recently used one is evicted. Use counts
// saturate. A request is taken when in_ready is high and its result is held in
// an output register, so the next request can be taken while a result waits.
// A get miss, or a put of a new key at zero capacity, passes the match and
// lookup states; a hit or a put into free space adds the hit or insert state;
// a put that must evict adds the victim scan, which visits one entry per
// cycle, then the pick and evict states. The next request is taken in the
// cycle after a result is loaded into the output register; a result that is
// not taken holds the following request before its output. Capacity (cfg_data)
// is read as min(capacity, ENTRIES); a capacity of zero makes puts of new keys
// return an all-zero result. Values live in a single-port-read RAM, keys,
// counts and recency ranks in registers; all entries are invalid after reset.
module lfu_cache_table #(
  parameter int ENTRIES    = lfuct_pkg::DEF_ENTRIES,
  parameter int COUNT_BITS = lfuct_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lfuct_pkg::CAP_BITS-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lfuct_pkg::req_t                in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lfuct_pkg::rsp_t                out_data
);

  import lfuct_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  lfuct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfuct_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/lfuct_ram.sv
module lfuct_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lfuct_ctrl.sv
module lfuct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lfuct_pkg::dp_sts_t  sts,
  output lfuct_pkg::dp_cmd_t  cmd
);

  import lfuct_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MATCH  = 4'd1;
  localparam logic [3:0] S_LOOK   = 4'd2;
  localparam logic [3:0] S_HIT    = 4'd3;
  localparam logic [3:0] S_INSERT = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_PICK   = 4'd6;
  localparam logic [3:0] S_EVICT  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_next   = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match_load = 1'b1;
        state_next     = S_LOOK;
      end
      S_LOOK: begin
        if (sts.found) begin
          state_next = S_HIT;
        end else if (!sts.is_put || sts.cap_zero) begin
          cmd.res_load = 1'b1;
          state_next   = S_OUT;
        end else if (!sts.full) begin
          cmd.free_load = 1'b1;
          state_next    = S_INSERT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_HIT: begin
        cmd.promote    = 1'b1;
        cmd.bump_count = 1'b1;
        cmd.val_write  = sts.is_put;
        cmd.res_load   = 1'b1;
        cmd.res_hit    = 1'b1;
        cmd.res_read   = 1'b1;
        state_next     = S_OUT;
      end
      S_INSERT: begin
        cmd.insert    = 1'b1;
        cmd.fill_slot = 1'b1;
        cmd.val_write = 1'b1;
        cmd.res_load  = 1'b1;
        state_next    = S_OUT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick_load = 1'b1;
        state_next    = S_EVICT;
      end
      S_EVICT: begin
        cmd.promote   = 1'b1;
        cmd.fill_slot = 1'b1;
        cmd.val_write = 1'b1;
        cmd.res_load  = 1'b1;
        cmd.res_evict = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lfuct_dp.sv
module lfuct_dp #(
  parameter int  ENTRIES    = lfuct_pkg::DEF_ENTRIES,
  parameter int  COUNT_BITS = lfuct_pkg::DEF_COUNT_BITS,
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int FILL_W     = $clog2(ENTRIES + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lfuct_pkg::CAP_BITS-1:0]      cfg_data,
  input  lfuct_pkg::req_t                     in_data,
  input  lfuct_pkg::dp_cmd_t                  cmd,
  output lfuct_pkg::dp_sts_t                  sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lfuct_pkg::rsp_t                     out_data
);

  import lfuct_pkg::*;

  localparam int CW = (FILL_W > CAP_BITS) ? FILL_W : CAP_BITS;

  req_t                  req;
  logic [CAP_BITS-1:0]   cap;
  logic [ENTRIES-1:0]    valid;
  logic [KEY_BITS-1:0]   keys   [ENTRIES];
  logic [COUNT_BITS-1:0] counts [ENTRIES];
  logic [IDX_W-1:0]      ranks  [ENTRIES];
  logic [FILL_W-1:0]     fill;
  logic [IDX_W-1:0]      ptr;
  logic                  found;
  logic                  best_valid;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [IDX_W-1:0]      best_rank;
  logic [IDX_W-1:0]      best_idx;
  rsp_t                  res;

  logic                  match_any;
  logic [IDX_W-1:0]      match_idx;
  logic [IDX_W-1:0]      free_idx;
  logic [CW-1:0]         cap_ext;
  logic [CW-1:0]         eff_cap;
  logic [IDX_W-1:0]      cur_rank;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic                  cand_better;
  logic [VALUE_BITS-1:0] ram_rdata;

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == req.lookup_key) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign cap_ext  = CW'(cap);
  assign eff_cap  = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
  assign cur_rank = ranks[ptr];
  assign cur_cnt  = counts[ptr];

  assign cand_better = valid[ptr] &&
                       (!best_valid || cur_cnt < best_cnt ||
                        (cur_cnt == best_cnt && cur_rank > best_rank));

  assign sts.found     = found;
  assign sts.is_put    = (req.opcode == OP_PUT);
  assign sts.cap_zero  = (cap == '0);
  assign sts.full      = (CW'(fill) >= eff_cap);
  assign sts.scan_last = (ptr == IDX_W'(ENTRIES - 1));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_write) begin
      cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill  <= '0;
    end else begin
      if (cmd.fill_slot) begin
        valid[ptr] <= 1'b1;
      end
      if (cmd.insert) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd.promote && valid[i] && ranks[i] < cur_rank) begin
        ranks[i] <= ranks[i] + 1'b1;
      end
      if (cmd.insert && valid[i]) begin
        ranks[i] <= ranks[i] + 1'b1;
      end
      if ((cmd.promote || cmd.fill_slot) && ptr == IDX_W'(i)) begin
        ranks[i] <= '0;
      end
      if (ptr == IDX_W'(i)) begin
        if (cmd.fill_slot) begin
          counts[i] <= COUNT_BITS'(1);
          keys[i]   <= req.lookup_key;
        end else if (cmd.bump_count && counts[i] != '1) begin
          counts[i] <= counts[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      found      <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      if (cmd.match_load) begin
        ptr   <= match_idx;
        found <= match_any;
      end else if (cmd.free_load) begin
        ptr <= free_idx;
      end else if (cmd.scan_start) begin
        ptr <= '0;
      end else if (cmd.scan_step) begin
        ptr <= ptr + 1'b1;
      end else if (cmd.pick_load) begin
        ptr <= best_idx;
      end
      if (cmd.scan_start) begin
        best_valid <= 1'b0;
      end else if (cmd.scan_step && cand_better) begin
        best_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && cand_better) begin
      best_cnt  <= cur_cnt;
      best_rank <= cur_rank;
      best_idx  <= ptr;
    end
  end

  lfuct_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (cmd.val_write),
    .waddr (ptr),
    .wdata (req.write_value),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res.hit         <= cmd.res_hit;
      res.read_value  <= (cmd.res_read && req.opcode == OP_GET) ? ram_rdata : '0;
      res.evicted     <= cmd.res_evict;
      res.evicted_key <= cmd.res_evict ? keys[ptr] : '0;
    end
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_fill_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    int'(fill) == $countones(valid))
    else $error("fill count differs from number of valid entries");

  a_victim_found: assert property (@(posedge clk) disable iff (rst)
    cmd.pick_load |-> best_valid)
    else $error("scan ended without a victim");

  a_promote_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.promote |-> valid[ptr])
    else $error("promote of an invalid entry");

  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !valid[ptr] && fill < FILL_W'(ENTRIES))
    else $error("insert into an occupied slot or a full table");

endmodule
